FILE: sv/dla_pkg.sv
// Shared constants, codes and types of the display lane allocator.
package dla_pkg;

    localparam int OPCODE_W        = 3;
    localparam int LANE_IDX_W      = 6;
    localparam int STATUS_W        = 2;
    localparam int LINES_W         = 7;
    localparam int SEED_W          = 16;
    localparam int LFSR_W          = 16;

    localparam int DEF_MAX_LANES   = 64;
    localparam int DEF_PROBE_TRIES = 6;
    localparam int HALF_PROBES     = 3;
    localparam int SCAN_W          = 8;

    localparam logic [LINES_W-1:0] LINES_RESET = 7'd64;
    localparam logic [SEED_W-1:0]  SEED_RESET  = 16'd1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register index, taken from paddr[2].
    localparam logic REG_LINES = 1'b0;
    localparam logic REG_SEED  = 1'b1;

    localparam logic [OPCODE_W-1:0] OP_ALLOC_MOVING = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_ALLOC_TOP    = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_ALLOC_BOTTOM = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_FREE_MOVING  = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_FREE_FIXED   = 3'd4;

    localparam logic [STATUS_W-1:0] STAT_GRANTED = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NONE    = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FREED   = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_RANGE   = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_STEP,
        ST_DIV,
        ST_PROBE,
        ST_SCAN,
        ST_RESULT
    } t_state;

    // Fibonacci LFSR, taps 16,14,13,11, shifting right.
    function automatic logic [LFSR_W-1:0] lfsr_next(input logic [LFSR_W-1:0] v);
        return {v[0] ^ v[2] ^ v[3] ^ v[5], v[LFSR_W-1:1]};
    endfunction

endpackage

FILE: sv/dla_if.sv
// Request and response channel interfaces of the display lane allocator.
interface dla_req_if import dla_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [OPCODE_W-1:0]   opcode;
    logic [LANE_IDX_W-1:0] lane_index;

    modport source (output valid, output opcode, output lane_index, input ready);
    modport sink   (input valid, input opcode, input lane_index, output ready);
endinterface

interface dla_rsp_if import dla_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [LANE_IDX_W-1:0] granted_lane;
    logic [STATUS_W-1:0]   status;

    modport source (output valid, output granted_lane, output status, input ready);
    modport sink   (input valid, input granted_lane, input status, output ready);
endinterface

FILE: sv/display_lane_allocator_unit.sv
// Display lane allocator: moving and fixed lane busy maps with a sequenced probe unit.
//
// One request is taken at a time; i_req.ready is high only while the block is idle.
// A moving allocation steps the LFSR and reduces it modulo the probe range with a
// shared restoring remainder unit, one bit per cycle; each probe is one LFSR step,
// one remainder step per dividend bit and one busy check, and a request makes up to
// PROBE_TRIES probes. Top and bottom allocations scan the fixed map eight lanes per
// cycle until a free lane or the end of the range is found. Frees and unknown opcodes
// pass through the execute state. The response sits in an output register, so a new
// request may be accepted while the previous response waits for o_rsp.ready.
module display_lane_allocator_unit import dla_pkg::*; #(
    parameter int MAX_LANES   = DEF_MAX_LANES,
    parameter int PROBE_TRIES = DEF_PROBE_TRIES
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    dla_req_if.sink               i_req,
    dla_rsp_if.source             o_rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LANE_W     = $clog2(MAX_LANES);
    localparam int NCHUNK     = (MAX_LANES + SCAN_W - 1) / SCAN_W;
    localparam int CHUNK_W    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
    localparam int PAD_W      = NCHUNK * SCAN_W;
    localparam int SCAN_IDX_W = $clog2(SCAN_W);
    localparam int TRY_W      = $clog2(PROBE_TRIES + 1);
    localparam int BIT_W      = $clog2(LFSR_W);

    t_state                  r_state, n_state;
    logic [LINES_W-1:0]      r_lines;
    logic [SEED_W-1:0]       r_seed;
    logic [LFSR_W-1:0]       r_lfsr;
    logic [MAX_LANES-1:0]    r_moving_busy;
    logic [MAX_LANES-1:0]    r_fixed_busy;
    logic [OPCODE_W-1:0]     r_op;
    logic [LANE_IDX_W-1:0]   r_idx;
    logic [TRY_W-1:0]        r_try;
    logic [LINES_W-1:0]      r_range;
    logic [LINES_W-1:0]      r_rem;
    logic [LFSR_W-1:0]       r_dvd;
    logic [BIT_W-1:0]        r_bit;
    logic [CHUNK_W-1:0]      r_chunk;
    logic [LANE_W-1:0]       r_res_lane;
    logic [STATUS_W-1:0]     r_res_status;
    logic                    r_out_valid;
    logic [LANE_IDX_W-1:0]   r_out_lane;
    logic [STATUS_W-1:0]     r_out_status;

    logic                    w_accept;
    logic                    w_out_load;
    logic                    w_cfg_wr;
    logic [LINES_W-1:0]      w_n;
    logic [LFSR_W-1:0]       w_lfsr_step;
    logic [LINES_W:0]        w_trial;
    logic                    w_trial_ge;
    logic [LINES_W-1:0]      w_rem_next;
    logic [LANE_W-1:0]       w_probe_lane;
    logic                    w_probe_busy;
    logic                    w_last_try;
    logic [PAD_W-1:0]        w_fixed_pad;
    logic [SCAN_W-1:0]       w_chunk_bits;
    logic [SCAN_W-1:0]       w_avail;
    logic [SCAN_IDX_W-1:0]   w_pick;
    logic                    w_scan_hit;
    logic [LANE_W-1:0]       w_scan_lane;
    logic                    w_scan_end;
    logic                    w_idx_ok;
    logic [LANE_W-1:0]       w_free_lane;
    logic [CHUNK_W-1:0]      w_bottom_start;

    // Lane count saturated to 2 .. MAX_LANES.
    always_comb begin
        if (r_lines < LINES_W'(2)) begin
            w_n = LINES_W'(2);
        end else if (32'(r_lines) > MAX_LANES) begin
            w_n = LINES_W'(MAX_LANES);
        end else begin
            w_n = r_lines;
        end
    end

    assign w_lfsr_step = lfsr_next(r_lfsr);

    // Restoring remainder step: one dividend bit per cycle.
    assign w_trial    = {r_rem, r_dvd[LFSR_W-1]};
    assign w_trial_ge = w_trial >= {1'b0, r_range};
    assign w_rem_next = w_trial_ge ? LINES_W'(w_trial - {1'b0, r_range})
                                   : w_trial[LINES_W-1:0];

    assign w_probe_lane = LANE_W'(r_rem);
    assign w_probe_busy = r_moving_busy[w_probe_lane];
    assign w_last_try   = (32'(r_try) + 1) >= PROBE_TRIES;

    // Fixed map scan, one group of eight lanes per cycle.
    assign w_fixed_pad  = PAD_W'(r_fixed_busy);
    assign w_chunk_bits = w_fixed_pad[{r_chunk, {SCAN_IDX_W{1'b0}}} +: SCAN_W];

    always_comb begin
        for (int k = 0; k < SCAN_W; k++) begin
            w_avail[k] = !w_chunk_bits[k]
                && (16'({r_chunk, SCAN_IDX_W'(k)}) < 16'(w_n));
        end
    end

    always_comb begin
        w_pick = '0;
        if (r_op == OP_ALLOC_TOP) begin
            for (int k = SCAN_W - 1; k >= 0; k--) begin
                if (w_avail[k]) begin
                    w_pick = SCAN_IDX_W'(k);
                end
            end
        end else begin
            for (int k = 0; k < SCAN_W; k++) begin
                if (w_avail[k]) begin
                    w_pick = SCAN_IDX_W'(k);
                end
            end
        end
    end

    assign w_scan_hit  = |w_avail;
    assign w_scan_lane = LANE_W'({r_chunk, w_pick});
    assign w_scan_end  = (r_op == OP_ALLOC_TOP)
        ? ((16'({r_chunk, {SCAN_IDX_W{1'b0}}}) + 16'(SCAN_W)) >= 16'(w_n))
        : (r_chunk == '0);
    assign w_bottom_start = CHUNK_W'((w_n - LINES_W'(1)) >> SCAN_IDX_W);

    assign w_idx_ok    = {1'b0, r_idx} < w_n;
    assign w_free_lane = LANE_W'(r_idx);

    // Handshake and strobe outputs of the sequencer.
    always_comb begin
        i_req.ready = (r_state == ST_IDLE);
        w_out_load  = (r_state == ST_RESULT) && (!r_out_valid || o_rsp.ready);
        w_cfg_wr    = psel && penable && pwrite;
    end

    assign w_accept = i_req.valid && i_req.ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    unique case (i_req.opcode)
                        OP_ALLOC_MOVING: n_state = ST_STEP;
                        OP_ALLOC_TOP:    n_state = ST_SCAN;
                        OP_ALLOC_BOTTOM: n_state = ST_SCAN;
                        default:         n_state = ST_EXEC;
                    endcase
                end
            end
            ST_EXEC:  n_state = ST_RESULT;
            ST_STEP:  n_state = ST_DIV;
            ST_DIV: begin
                if (r_bit == '1) begin
                    n_state = ST_PROBE;
                end
            end
            ST_PROBE: begin
                if (!w_probe_busy || w_last_try) begin
                    n_state = ST_RESULT;
                end else begin
                    n_state = ST_STEP;
                end
            end
            ST_SCAN: begin
                if (w_scan_hit || w_scan_end) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (w_out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // Control state, maps and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_lines       <= LINES_RESET;
            r_seed        <= SEED_RESET;
            r_lfsr        <= SEED_RESET;
            r_moving_busy <= '0;
            r_fixed_busy  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (w_cfg_wr && paddr[2] == REG_SEED) begin
                r_seed <= pwdata[SEED_W-1:0];
                r_lfsr <= (pwdata[SEED_W-1:0] == '0) ? LFSR_W'(1) : pwdata[SEED_W-1:0];
            end else if (r_state == ST_STEP) begin
                r_lfsr <= w_lfsr_step;
            end
            if (w_cfg_wr && paddr[2] == REG_LINES) begin
                r_lines <= pwdata[LINES_W-1:0];
            end

            if (r_state == ST_PROBE && !w_probe_busy) begin
                r_moving_busy[w_probe_lane] <= 1'b1;
            end
            if (r_state == ST_SCAN && w_scan_hit) begin
                r_fixed_busy[w_scan_lane] <= 1'b1;
            end
            if (r_state == ST_EXEC && w_idx_ok) begin
                if (r_op == OP_FREE_MOVING) begin
                    r_moving_busy[w_free_lane] <= 1'b0;
                end else if (r_op == OP_FREE_FIXED) begin
                    r_fixed_busy[w_free_lane] <= 1'b0;
                end
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working registers of the request in flight.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    r_op         <= i_req.opcode;
                    r_idx        <= i_req.lane_index;
                    r_try        <= '0;
                    r_res_lane   <= '0;
                    r_res_status <= STAT_NONE;
                    r_chunk      <= (i_req.opcode == OP_ALLOC_BOTTOM) ? w_bottom_start : '0;
                end
            end
            ST_EXEC: begin
                case (r_op) inside
                    OP_FREE_MOVING, OP_FREE_FIXED:
                        r_res_status <= w_idx_ok ? STAT_FREED : STAT_RANGE;
                    default:
                        r_res_status <= STAT_NONE;
                endcase
            end
            ST_STEP: begin
                r_range <= (32'(r_try) < HALF_PROBES) ? (w_n >> 1) : w_n;
                r_dvd   <= w_lfsr_step;
                r_rem   <= '0;
                r_bit   <= '0;
            end
            ST_DIV: begin
                r_rem <= w_rem_next;
                r_dvd <= {r_dvd[LFSR_W-2:0], 1'b0};
                r_bit <= r_bit + BIT_W'(1);
            end
            ST_PROBE: begin
                if (!w_probe_busy) begin
                    r_res_lane   <= w_probe_lane;
                    r_res_status <= STAT_GRANTED;
                end else begin
                    r_try <= r_try + TRY_W'(1);
                end
            end
            ST_SCAN: begin
                if (w_scan_hit) begin
                    r_res_lane   <= w_scan_lane;
                    r_res_status <= STAT_GRANTED;
                end else if (r_op == OP_ALLOC_TOP) begin
                    r_chunk <= r_chunk + CHUNK_W'(1);
                end else begin
                    r_chunk <= r_chunk - CHUNK_W'(1);
                end
            end
            default: begin
            end
        endcase

        if (w_out_load) begin
            r_out_lane   <= LANE_IDX_W'(r_res_lane);
            r_out_status <= r_res_status;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.granted_lane = r_out_lane;
    assign o_rsp.status       = r_out_status;

    assign pready = 1'b1;

    always_comb begin
        unique case (paddr[2])
            REG_SEED:  prdata = APB_DATA_W'(r_seed);
            REG_LINES: prdata = APB_DATA_W'(r_lines);
            default:   prdata = '0;
        endcase
    end

endmodule

FILE: sv/dla_checker.sv
// Port-level checks of the display lane allocator and their bind to the top level.
module dla_checker import dla_pkg::*; (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  req_valid,
    input logic                  req_ready,
    input logic                  rsp_valid,
    input logic                  rsp_ready,
    input logic [LANE_IDX_W-1:0] rsp_lane,
    input logic [STATUS_W-1:0]   rsp_status
);

    // A stalled response beat keeps its contents.
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_lane) && $stable(rsp_status))
        else $error("response beat changed while stalled");

    // Only a grant carries a lane number.
    a_lane_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_status != STAT_GRANTED |-> rsp_lane == '0)
        else $error("lane number on a response that grants nothing");

    // The allocator works on one request at a time.
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while another is in work");

    // Reset leaves no response pending and the block idle.
    a_reset_idle: assert property (@(posedge clk)
        !rst_n |=> !rsp_valid && req_ready)
        else $error("block not idle after reset");

endmodule

bind display_lane_allocator_unit dla_checker u_dla_checker (
    .clk        (i_clk),
    .rst_n      (i_rst_n),
    .req_valid  (i_req.valid),
    .req_ready  (i_req.ready),
    .rsp_valid  (o_rsp.valid),
    .rsp_ready  (o_rsp.ready),
    .rsp_lane   (o_rsp.granted_lane),
    .rsp_status (o_rsp.status)
);
